[hw/rtl/ddpd_pkg.sv]
package ddpd_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 12;

  localparam int TICK_W  = 32;
  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 10;
  localparam int IVL_W   = 16;
  localparam int PER_W   = 16;
  localparam int DRIVE_W = 11;
  localparam int ERR_W   = 17;
  localparam int MAG_W   = 10;
  localparam int CMP_W   = 16;

  // stage registers from the first lane stage up to the last one before the output
  localparam int STAGES = 7;

  localparam int IN_W  = TICK_W + 4 * SPEED_W;
  localparam int OUT_W = 88;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P        = 3'd0,
    REG_GAIN_I        = 3'd1,
    REG_GAIN_D        = 3'd2,
    REG_DELTA_LIMIT   = 3'd3,
    REG_OUTPUT_LIMIT  = 3'd4,
    REG_INTERVAL_MS   = 3'd5,
    REG_BRIDGE_PERIOD = 3'd6
  } reg_idx_t;

  localparam logic [GAIN_W-1:0]  GAIN_P_RST        = 16'd3277;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST        = 16'd614;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST        = 16'd0;
  localparam logic [LIMIT_W-1:0] DELTA_LIMIT_RST   = 10'd100;
  localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST  = 10'd999;
  localparam logic [IVL_W-1:0]   INTERVAL_MS_RST   = 16'd2;
  localparam logic [PER_W-1:0]   BRIDGE_PERIOD_RST = 16'd4000;

  localparam logic [MAG_W-1:0] DUTY_MAG_MAX = 10'd999;

  // x / 1000 == ((x >> 3) * RECIP_125) >> RECIP_SHIFT, exact for x < 2^26
  localparam int                RECIP_SHIFT = 30;
  localparam int                RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP_125  = 24'd8589935;
  localparam int                DUTY_PROD_W = MAG_W + PER_W;
  localparam int                DUTY_Y_W    = DUTY_PROD_W - 3;
  localparam int                DUTY_M_W    = DUTY_Y_W + RECIP_W;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] delta_limit;
    logic [LIMIT_W-1:0] output_limit;
    logic [PER_W-1:0]   bridge_period;
  } cfg_t;

  // adv[k] loads stage k+1 of every lane with a valid item
  typedef struct packed {
    logic [STAGES-1:0] adv;
  } ctrl_t;

endpackage

[hw/rtl/ddpd_bridge.sv]
module ddpd_bridge
  import ddpd_pkg::*;
(
  input  logic                      clk,
  input  logic                      load_prod,
  input  logic                      load_recip,
  input  logic [PER_W-1:0]          bridge_period,
  input  logic signed [DRIVE_W-1:0] drive,
  output logic signed [DRIVE_W-1:0] drive_out,
  output logic [CMP_W-1:0]          compare_a,
  output logic [CMP_W-1:0]          compare_b
);

  logic [DRIVE_W-1:0]          abs_drive;
  logic [MAG_W-1:0]            mag;
  logic [DUTY_PROD_W-1:0]      prod;
  logic signed [DRIVE_W-1:0]   drive_p;
  logic                        zero_p;
  logic                        neg_p;
  logic [DUTY_M_W-1:0]         prod_m;
  logic signed [DRIVE_W-1:0]   drive_m;
  logic                        zero_m;
  logic                        neg_m;
  logic [CMP_W-1:0]            duty;

  always_comb begin
    abs_drive = drive[DRIVE_W-1] ? DRIVE_W'(-drive) : DRIVE_W'(drive);
    if (abs_drive > DRIVE_W'(DUTY_MAG_MAX)) begin
      mag = DUTY_MAG_MAX;
    end else begin
      mag = abs_drive[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_prod) begin
      prod    <= DUTY_PROD_W'(mag) * DUTY_PROD_W'(bridge_period);
      drive_p <= drive;
      zero_p  <= (drive == '0);
      neg_p   <= drive[DRIVE_W-1];
    end
    if (load_recip) begin
      prod_m  <= DUTY_M_W'(prod[DUTY_PROD_W-1:3]) * DUTY_M_W'(RECIP_125);
      drive_m <= drive_p;
      zero_m  <= zero_p;
      neg_m   <= neg_p;
    end
  end

  assign duty      = prod_m[RECIP_SHIFT+CMP_W-1:RECIP_SHIFT];
  assign drive_out = drive_m;

  always_comb begin
    if (zero_m || !neg_m) begin
      compare_a = bridge_period;
    end else begin
      compare_a = duty;
    end
    if (zero_m || neg_m) begin
      compare_b = bridge_period;
    end else begin
      compare_b = duty;
    end
  end

endmodule

[hw/rtl/ddpd_lane.sv]
module ddpd_lane
  import ddpd_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_t                     ctrl,
  input  cfg_t                      cfg,
  input  logic signed [SPEED_W-1:0] target,
  input  logic signed [SPEED_W-1:0] measured,
  output logic signed [DRIVE_W-1:0] drive,
  output logic [CMP_W-1:0]          compare_a,
  output logic [CMP_W-1:0]          compare_b
);

  localparam int DE_W  = ERR_W + 1;
  localparam int DD_W  = ERR_W + 2;
  localparam int PP_W  = GAIN_W + 1 + DE_W;
  localparam int PI_W  = GAIN_W + 1 + ERR_W;
  localparam int PD_W  = GAIN_W + 1 + DD_W;
  localparam int SUM_W = PD_W + 2;
  localparam logic [SUM_W-1:0] ROUND_BIAS =
    (SUM_W'(1) << GAIN_FRAC_BITS) - SUM_W'(1);

  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   last_error;
  logic signed [ERR_W-1:0]   error_before_last;
  logic signed [DE_W-1:0]    de;
  logic signed [ERR_W-1:0]   ei;
  logic signed [DD_W-1:0]    dd;
  logic signed [PP_W-1:0]    pp;
  logic signed [PI_W-1:0]    pi;
  logic signed [PD_W-1:0]    pd;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   sum_biased;
  logic signed [SUM_W-1:0]   quot;
  logic signed [SUM_W-1:0]   dlim_pos;
  logic signed [DRIVE_W-1:0] delta_next;
  logic signed [DRIVE_W-1:0] delta;
  logic signed [DRIVE_W:0]   level_sum;
  logic signed [DRIVE_W:0]   olim_pos;
  logic signed [DRIVE_W-1:0] drive_level;
  logic signed [DRIVE_W-1:0] drive_level_next;

  assign err = ERR_W'(target) - ERR_W'(measured);

  // error history moves as soon as the item is taken, so the next item sees it
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error        <= '0;
      error_before_last <= '0;
    end else if (ctrl.adv[0]) begin
      last_error        <= err;
      error_before_last <= last_error;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[0]) begin
      de <= DE_W'(err) - DE_W'(last_error);
      ei <= err;
      dd <= DD_W'(err) - (DD_W'(last_error) <<< 1) + DD_W'(error_before_last);
    end
    if (ctrl.adv[1]) begin
      pp <= signed'(PP_W'(cfg.gain_p)) * PP_W'(de);
      pi <= signed'(PI_W'(cfg.gain_i)) * PI_W'(ei);
      pd <= signed'(PD_W'(cfg.gain_d)) * PD_W'(dd);
    end
    if (ctrl.adv[2]) begin
      sum <= SUM_W'(pp) + SUM_W'(pi) + SUM_W'(pd);
    end
    if (ctrl.adv[3]) begin
      delta <= delta_next;
    end
  end

  // truncate toward zero: bias negative sums before the arithmetic shift
  always_comb begin
    sum_biased = sum + (sum[SUM_W-1] ? signed'(ROUND_BIAS) : SUM_W'(0));
    quot       = sum_biased >>> GAIN_FRAC_BITS;
    dlim_pos   = signed'(SUM_W'(cfg.delta_limit));
    if (quot > dlim_pos) begin
      delta_next = DRIVE_W'(dlim_pos);
    end else if (quot < -dlim_pos) begin
      delta_next = DRIVE_W'(-dlim_pos);
    end else begin
      delta_next = quot[DRIVE_W-1:0];
    end
  end

  always_comb begin
    level_sum = (DRIVE_W+1)'(drive_level) + (DRIVE_W+1)'(delta);
    olim_pos  = signed'((DRIVE_W+1)'(cfg.output_limit));
    if (level_sum > olim_pos) begin
      drive_level_next = DRIVE_W'(olim_pos);
    end else if (level_sum < -olim_pos) begin
      drive_level_next = DRIVE_W'(-olim_pos);
    end else begin
      drive_level_next = level_sum[DRIVE_W-1:0];
    end
  end

  // the accumulated level doubles as the fifth stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_level <= '0;
    end else if (ctrl.adv[4]) begin
      drive_level <= drive_level_next;
    end
  end

  ddpd_bridge u_bridge (
    .clk           (clk),
    .load_prod     (ctrl.adv[5]),
    .load_recip    (ctrl.adv[6]),
    .bridge_period (cfg.bridge_period),
    .drive         (drive_level),
    .drive_out     (drive),
    .compare_a     (compare_a),
    .compare_b     (compare_b)
  );

endmodule

[hw/rtl/dual_incremental_pid_pwm_drive_unit.sv]
// Dual-wheel incremental PID speed loop with H-bridge compare outputs.
// Slave stream s_t*: one item per control tick (tick, two targets, two speeds).
// An item whose tick is less than interval_ms after the last update is taken
// and dropped with no result; any other item updates both wheels and yields
// one result on the master stream m_t* (two drive levels, four compares).
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Registers must be written only while no item is in flight; the
// user is bound by this and the block does not enforce it. Results pass the
// seven lane stages and the output register. Throughput: one item per cycle
// unless m_tready stalls; each wheel has its own lane and drive_level loop.
// Reset: registers return to their defaults, error history, drive levels and
// the last update tick clear, and the pipeline empties.
// Stall: while m_tready is low the result holds and items keep entering until
// the seven lane stages are full; then s_tready drops.
module dual_incremental_pid_pwm_drive_unit
  import ddpd_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // now_tick[31:0], target_left, target_right, measured_left, measured_right
  input  logic [IN_W-1:0]       s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // left_drive[10:0], right_drive, left_compare_a, left_compare_b,
  // right_compare_a, right_compare_b, two zero bits
  output logic [OUT_W-1:0]      m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                      cfg;
  logic [IVL_W-1:0]          interval_ms;
  logic [TICK_W-1:0]         last_update_tick;
  logic [TICK_W-1:0]         now_tick;
  logic                      due;
  logic [STAGES-1:0]         valid;
  logic [STAGES-1:0]         rdy;
  logic                      rdy_out;
  ctrl_t                     ctrl;
  logic signed [DRIVE_W-1:0] drive_l;
  logic signed [DRIVE_W-1:0] drive_r;
  logic [CMP_W-1:0]          cmp_la;
  logic [CMP_W-1:0]          cmp_lb;
  logic [CMP_W-1:0]          cmp_ra;
  logic [CMP_W-1:0]          cmp_rb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p        <= GAIN_P_RST;
      cfg.gain_i        <= GAIN_I_RST;
      cfg.gain_d        <= GAIN_D_RST;
      cfg.delta_limit   <= DELTA_LIMIT_RST;
      cfg.output_limit  <= OUTPUT_LIMIT_RST;
      cfg.bridge_period <= BRIDGE_PERIOD_RST;
      interval_ms       <= INTERVAL_MS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN_P:        cfg.gain_p        <= cfg_data;
        REG_GAIN_I:        cfg.gain_i        <= cfg_data;
        REG_GAIN_D:        cfg.gain_d        <= cfg_data;
        REG_DELTA_LIMIT:   cfg.delta_limit   <= cfg_data[LIMIT_W-1:0];
        REG_OUTPUT_LIMIT:  cfg.output_limit  <= cfg_data[LIMIT_W-1:0];
        REG_INTERVAL_MS:   interval_ms       <= cfg_data;
        REG_BRIDGE_PERIOD: cfg.bridge_period <= cfg_data;
        default: ;
      endcase
    end
  end

  assign now_tick = s_tdata[TICK_W-1:0];
  assign due      = (now_tick - last_update_tick) >= TICK_W'(interval_ms);

  // each stage takes a new item when empty or when its own item moves on
  always_comb begin
    rdy_out         = !m_tvalid || m_tready;
    rdy[STAGES-1]   = !valid[STAGES-1] || rdy_out;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
    s_tready    = rdy[0];
    ctrl.adv[0] = s_tvalid && rdy[0] && due;
    for (int k = 1; k < STAGES; k++) begin
      ctrl.adv[k] = rdy[k] && valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid            <= '0;
      m_tvalid         <= 1'b0;
      last_update_tick <= '0;
    end else begin
      if (ctrl.adv[0]) begin
        last_update_tick <= now_tick;
      end
      if (rdy[0]) begin
        valid[0] <= ctrl.adv[0];
      end
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) begin
          valid[k] <= valid[k-1];
        end
      end
      if (rdy_out) begin
        m_tvalid <= valid[STAGES-1];
      end
    end
  end

  ddpd_lane #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_lane_left (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .target    (s_tdata[TICK_W+SPEED_W-1:TICK_W]),
    .measured  (s_tdata[TICK_W+3*SPEED_W-1:TICK_W+2*SPEED_W]),
    .drive     (drive_l),
    .compare_a (cmp_la),
    .compare_b (cmp_lb)
  );

  ddpd_lane #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_lane_right (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .target    (s_tdata[TICK_W+2*SPEED_W-1:TICK_W+SPEED_W]),
    .measured  (s_tdata[TICK_W+4*SPEED_W-1:TICK_W+3*SPEED_W]),
    .drive     (drive_r),
    .compare_a (cmp_ra),
    .compare_b (cmp_rb)
  );

  // merge both lanes into the output register
  always_ff @(posedge clk) begin
    if (rdy_out && valid[STAGES-1]) begin
      m_tdata <= {2'b00, cmp_rb, cmp_ra, cmp_lb, cmp_la, drive_r, drive_l};
    end
  end

endmodule
